// File: design/fixed_step_tick_accumulator_assert.svh
// assertion macros shared by the checker file
`ifndef FIXED_STEP_TICK_ACCUMULATOR_ASSERT_SVH
`define FIXED_STEP_TICK_ACCUMULATOR_ASSERT_SVH

// condition in one cycle implies a condition in the next cycle
`define FSTA_ASSERT_NEXT(label, clk, rst_n, pre, post) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (pre) |=> (post)) \
    else $error("fsta assertion failed: next-cycle check");

// condition implies a condition in the same cycle
`define FSTA_ASSERT_SAME(label, clk, rst_n, pre, post) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (pre) |-> (post)) \
    else $error("fsta assertion failed: same-cycle check");

`endif

// File: design/fsta_pkg.sv
`timescale 1ns / 1ps

package fsta_pkg;

  // field widths
  localparam int unsigned PeriodW  = 24;
  localparam int unsigned ScaleW   = 16;
  localparam int unsigned FrameW   = 24;
  localparam int unsigned DeltaW   = 32;
  localparam int unsigned AccW     = 32;
  localparam int unsigned PendW    = 32;
  localparam int unsigned CountW   = 64;
  localparam int unsigned CmdW     = 3;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 24;
  localparam int unsigned FracW    = 8;

  // product of delta and scale, and divider sizes
  localparam int unsigned ProdW   = DeltaW + ScaleW;
  localparam int unsigned DivW    = ProdW - FracW;
  localparam int unsigned DivCntW = $clog2(DivW + 1);

  // register reset values
  localparam logic [PeriodW-1:0] DefTickPeriod = PeriodW'(16667);
  localparam logic [ScaleW-1:0]  DefTimeScale  = ScaleW'(256);
  localparam logic [FrameW-1:0]  DefMaxFrame   = FrameW'(250000);

  typedef enum logic [CmdW-1:0] {
    CMD_ADVANCE = 3'd0,
    CMD_CONSUME = 3'd1,
    CMD_DROP    = 3'd2,
    CMD_TAKE    = 3'd3,
    CMD_RESTORE = 3'd4
  } cmd_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_TICK_PERIOD = 2'd0,
    CFG_TIME_SCALE  = 2'd1,
    CFG_MAX_FRAME   = 2'd2
  } cfg_idx_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LOST_MUL,
    ST_LOST_START,
    ST_LOST_WAIT,
    ST_SUM_MUL,
    ST_SUM_ADD,
    ST_SUM_START,
    ST_SUM_WAIT,
    ST_FINISH
  } state_e;

  typedef struct packed {
    logic [PeriodW-1:0] tick_period;
    logic [ScaleW-1:0]  time_scale;
    logic [FrameW-1:0]  max_frame;
  } cfg_t;

  // divider done flag and results
  typedef struct packed {
    logic                done;
    logic [DivW-1:0]     quotient;
    logic [PeriodW-1:0]  remainder;
  } div_res_t;

endpackage

// File: design/fsta_cfg.sv
`timescale 1ns / 1ps

module fsta_cfg (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [fsta_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [fsta_pkg::CfgDataW-1:0]  cfg_data_i,
  output fsta_pkg::cfg_t                 cfg_o
);

  logic [fsta_pkg::PeriodW-1:0] period_q;
  logic [fsta_pkg::ScaleW-1:0]  scale_q;
  logic [fsta_pkg::FrameW-1:0]  frame_q;

  // register writes, unknown indexes ignored
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      period_q <= fsta_pkg::DefTickPeriod;
      scale_q  <= fsta_pkg::DefTimeScale;
      frame_q  <= fsta_pkg::DefMaxFrame;
    end else if (cfg_we_i) begin
      unique case (fsta_pkg::cfg_idx_e'(cfg_index_i))
        fsta_pkg::CFG_TICK_PERIOD: period_q <= cfg_data_i[fsta_pkg::PeriodW-1:0];
        fsta_pkg::CFG_TIME_SCALE:  scale_q  <= cfg_data_i[fsta_pkg::ScaleW-1:0];
        fsta_pkg::CFG_MAX_FRAME:   frame_q  <= cfg_data_i[fsta_pkg::FrameW-1:0];
        default: ;
      endcase
    end
  end

  // a zero period falls back to the default period
  always_comb begin
    cfg_o.tick_period = (period_q == '0) ? fsta_pkg::DefTickPeriod : period_q;
    cfg_o.time_scale  = scale_q;
    cfg_o.max_frame   = frame_q;
  end

endmodule

// File: design/fsta_div.sv
`timescale 1ns / 1ps

module fsta_div (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [fsta_pkg::DivW-1:0]     dividend_i,
  input  logic [fsta_pkg::PeriodW-1:0]  divisor_i,
  output fsta_pkg::div_res_t            res_o
);

  logic [fsta_pkg::DivW-1:0]    quo_q, quo_d;
  logic [fsta_pkg::PeriodW-1:0] rem_q, rem_d;
  logic [fsta_pkg::PeriodW-1:0] dvs_q;
  logic [fsta_pkg::DivCntW-1:0] cnt_q, cnt_d;
  logic                         done_q, done_d;
  logic [fsta_pkg::PeriodW:0]   trial;
  logic                         fits;

  // one restoring step: shift in next dividend bit, subtract if it fits
  always_comb begin
    trial = {rem_q, quo_q[fsta_pkg::DivW-1]};
    fits  = (trial >= {1'b0, dvs_q});
    quo_d = quo_q;
    rem_d = rem_q;
    cnt_d = cnt_q;
    done_d = 1'b0;
    if (start_i) begin
      quo_d = dividend_i;
      rem_d = '0;
      cnt_d = fsta_pkg::DivCntW'(fsta_pkg::DivW);
    end else if (cnt_q != '0) begin
      quo_d = {quo_q[fsta_pkg::DivW-2:0], fits};
      rem_d = fits ? fsta_pkg::PeriodW'(trial - {1'b0, dvs_q})
                   : trial[fsta_pkg::PeriodW-1:0];
      cnt_d = cnt_q - 1'b1;
      done_d = (cnt_q == fsta_pkg::DivCntW'(1));
    end
  end

  // step counter and done pulse
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      done_q <= done_d;
    end
  end

  // operand and partial results
  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    if (start_i) begin
      dvs_q <= divisor_i;
    end
  end

  assign res_o.done      = done_q;
  assign res_o.quotient  = quo_q;
  assign res_o.remainder = rem_q;

endmodule

// File: design/fixed_step_tick_accumulator.sv
`timescale 1ns / 1ps

// Fixed-step tick accumulator.
// Requests enter on the input channel (in_valid_i / in_stall_o) with a command,
// an elapsed time, a hold flag and a restore value; each request returns
// exactly one result on the output channel (out_valid_o / out_stall_i).
// Configuration (tick period, Q8.8 time scale, max frame) is written through
// cfg_we_i / cfg_index_i / cfg_data_i; the user must write it only while no
// request is in flight, the block does not enforce this. Consume, drop, take,
// restore and a held or zero-delta advance go straight to the finish state.
// A normal advance runs a multiply step and an add step, then 40 steps of
// the shared radix-2 divider that splits the scaled time into whole ticks.
// An advance whose delta exceeds the max frame runs the divider a second time
// for the lost time.
// The divider sets the rate; one request is worked on at a time and
// in_stall_o is high until its result has been loaded into the output register.
// A held result stays in the output register while out_stall_i is high, and
// the next request is accepted in the meantime.
// Reset clears accumulator, pending ticks and both counters and loads the
// default configuration.
module fixed_step_tick_accumulator (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [fsta_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [fsta_pkg::CfgDataW-1:0]  cfg_data_i,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [fsta_pkg::CmdW-1:0]      command_i,
  input  logic [fsta_pkg::DeltaW-1:0]    delta_us_i,
  input  logic                           hold_i,
  input  logic [fsta_pkg::CountW-1:0]    restore_value_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic                           granted_o,
  output logic [fsta_pkg::PendW-1:0]     ticks_due_o,
  output logic [fsta_pkg::CountW-1:0]    dropped_taken_o,
  output logic [fsta_pkg::CountW-1:0]    tick_total_o
);

  fsta_pkg::cfg_t     cfg;
  fsta_pkg::div_res_t div_res;
  fsta_pkg::state_e   state_q, state_d;

  logic [fsta_pkg::AccW-1:0]   acc_q;
  logic [fsta_pkg::PendW-1:0]  pend_q;
  logic [fsta_pkg::CountW-1:0] tick_q;
  logic [fsta_pkg::CountW-1:0] drop_q;

  logic [fsta_pkg::FrameW-1:0] clamp_q;
  logic [fsta_pkg::DeltaW-1:0] excess_q;
  logic [fsta_pkg::ProdW-1:0]  prod_q;
  logic                        granted_q;
  logic [fsta_pkg::CountW-1:0] taken_q;
  logic                        out_valid_q;

  logic                        req_accept;
  logic                        div_start;
  logic                        out_load;
  logic                        over_frame;
  logic                        adv_idle;
  logic [fsta_pkg::FrameW-1:0] clamp_w;
  logic [fsta_pkg::DeltaW-1:0] mul_a;
  logic [fsta_pkg::ProdW-1:0]  prod_w;
  logic                        sat;
  fsta_pkg::cmd_e              cmd;

  fsta_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  // shared divider, dividend drops the 8 fraction bits of the product
  fsta_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (prod_q[fsta_pkg::ProdW-1:fsta_pkg::FracW]),
    .divisor_i  (cfg.tick_period),
    .res_o      (div_res)
  );

  // request decode
  assign cmd        = fsta_pkg::cmd_e'(command_i);
  assign over_frame = delta_us_i > fsta_pkg::DeltaW'(cfg.max_frame);
  assign clamp_w    = over_frame ? cfg.max_frame : delta_us_i[fsta_pkg::FrameW-1:0];
  assign adv_idle   = hold_i || (delta_us_i == '0);

  // shared multiplier: lost time or clamped time by the scale
  assign mul_a  = (state_q == fsta_pkg::ST_LOST_MUL) ? excess_q
                                                     : fsta_pkg::DeltaW'(clamp_q);
  assign prod_w = fsta_pkg::ProdW'(mul_a) * fsta_pkg::ProdW'(cfg.time_scale);

  assign sat = div_res.quotient[fsta_pkg::DivW-1:fsta_pkg::PendW] != '0;

  // sequencer state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= fsta_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state and control
  always_comb begin
    state_d    = state_q;
    req_accept = 1'b0;
    div_start  = 1'b0;
    out_load   = 1'b0;
    in_stall_o = 1'b1;
    unique case (state_q)
      fsta_pkg::ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          req_accept = 1'b1;
          if (cmd == fsta_pkg::CMD_ADVANCE && !adv_idle) begin
            state_d = over_frame ? fsta_pkg::ST_LOST_MUL : fsta_pkg::ST_SUM_MUL;
          end else begin
            state_d = fsta_pkg::ST_FINISH;
          end
        end
      end
      fsta_pkg::ST_LOST_MUL:   state_d = fsta_pkg::ST_LOST_START;
      fsta_pkg::ST_LOST_START: begin
        div_start = 1'b1;
        state_d   = fsta_pkg::ST_LOST_WAIT;
      end
      fsta_pkg::ST_LOST_WAIT: begin
        if (div_res.done) begin
          state_d = fsta_pkg::ST_SUM_MUL;
        end
      end
      fsta_pkg::ST_SUM_MUL:    state_d = fsta_pkg::ST_SUM_ADD;
      fsta_pkg::ST_SUM_ADD:    state_d = fsta_pkg::ST_SUM_START;
      fsta_pkg::ST_SUM_START: begin
        div_start = 1'b1;
        state_d   = fsta_pkg::ST_SUM_WAIT;
      end
      fsta_pkg::ST_SUM_WAIT: begin
        if (div_res.done) begin
          state_d = fsta_pkg::ST_FINISH;
        end
      end
      fsta_pkg::ST_FINISH: begin
        if (!out_valid_q || !out_stall_i) begin
          out_load = 1'b1;
          state_d  = fsta_pkg::ST_IDLE;
        end
      end
      default: state_d = fsta_pkg::ST_IDLE;
    endcase
  end

  // architectural state: accumulator, pending ticks and counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q  <= '0;
      pend_q <= '0;
      tick_q <= '0;
      drop_q <= '0;
    end else begin
      if (req_accept) begin
        unique case (cmd)
          fsta_pkg::CMD_ADVANCE: begin
            if (adv_idle) begin
              pend_q <= '0;
            end
          end
          fsta_pkg::CMD_CONSUME: begin
            if (pend_q != '0) begin
              pend_q <= pend_q - 1'b1;
              tick_q <= tick_q + 1'b1;
            end
          end
          fsta_pkg::CMD_DROP: begin
            drop_q <= drop_q + fsta_pkg::CountW'(pend_q);
            pend_q <= '0;
          end
          fsta_pkg::CMD_TAKE: drop_q <= '0;
          fsta_pkg::CMD_RESTORE: begin
            tick_q <= restore_value_i;
            acc_q  <= '0;
            pend_q <= '0;
          end
          default: ;
        endcase
      end
      // lost time counts as dropped ticks
      if (state_q == fsta_pkg::ST_LOST_WAIT && div_res.done) begin
        drop_q <= drop_q + fsta_pkg::CountW'(div_res.quotient);
      end
      // whole ticks become pending, remainder stays with its fraction
      if (state_q == fsta_pkg::ST_SUM_WAIT && div_res.done) begin
        pend_q <= sat ? '1 : div_res.quotient[fsta_pkg::PendW-1:0];
        acc_q  <= {div_res.remainder, prod_q[fsta_pkg::FracW-1:0]};
      end
    end
  end

  // per-request working registers
  always_ff @(posedge clk_i) begin
    if (req_accept) begin
      clamp_q   <= clamp_w;
      excess_q  <= delta_us_i - fsta_pkg::DeltaW'(clamp_w);
      granted_q <= (cmd == fsta_pkg::CMD_CONSUME) && (pend_q != '0);
      taken_q   <= (cmd == fsta_pkg::CMD_TAKE) ? drop_q : '0;
    end
    if (state_q == fsta_pkg::ST_LOST_MUL || state_q == fsta_pkg::ST_SUM_MUL) begin
      prod_q <= prod_w;
    end else if (state_q == fsta_pkg::ST_SUM_ADD) begin
      prod_q <= prod_q + fsta_pkg::ProdW'(acc_q);
    end
  end

  // output register valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // output payload
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      granted_o       <= granted_q;
      ticks_due_o     <= pend_q;
      dropped_taken_o <= taken_q;
      tick_total_o    <= tick_q;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

// File: design/fsta_checker.sv
`timescale 1ns / 1ps

`include "fixed_step_tick_accumulator_assert.svh"

module fsta_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           in_valid_i,
  input logic                           in_stall_o,
  input logic                           out_valid_o,
  input logic                           out_stall_i,
  input logic                           granted_o,
  input logic [fsta_pkg::CountW-1:0]    dropped_taken_o
);

  // a result held by the receiver stays offered
  `FSTA_ASSERT_NEXT(a_out_held, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o)

  // one request at a time: busy right after a request is taken
  `FSTA_ASSERT_NEXT(a_busy_after_req, clk_i, rst_ni, in_valid_i && !in_stall_o, in_stall_o)

  // a granted tick never carries a dropped count
  `FSTA_ASSERT_SAME(a_grant_no_take, clk_i, rst_ni, out_valid_o && granted_o, dropped_taken_o == '0)

endmodule

bind fixed_step_tick_accumulator fsta_checker u_fsta_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_valid_i      (in_valid_i),
  .in_stall_o      (in_stall_o),
  .out_valid_o     (out_valid_o),
  .out_stall_i     (out_stall_i),
  .granted_o       (granted_o),
  .dropped_taken_o (dropped_taken_o)
);

// File: dv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import fsta_pkg::*;

  localparam int unsigned TimeoutCycles = 1_000_000;
  localparam int unsigned DrainCycles   = 120;
  localparam int unsigned HoldOffCycles = 300;
  localparam logic [CmdW-1:0] CmdUnusedLo  = 3'd5;
  localparam logic [CmdW-1:0] CmdUnusedMid = 3'd6;
  localparam logic [CmdW-1:0] CmdUnusedHi  = 3'd7;

  typedef struct {
    logic              granted;
    logic [PendW-1:0]  ticks_due;
    logic [CountW-1:0] dropped_taken;
    logic [CountW-1:0] tick_total;
  } tick_report_t;

  // clock and reset
  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;
  always #5 clk_i = ~clk_i;

  // block ports
  logic                cfg_we_i        = 1'b0;
  logic [CfgIdxW-1:0]  cfg_index_i     = '0;
  logic [CfgDataW-1:0] cfg_data_i      = '0;
  logic                in_valid_i      = 1'b0;
  logic                in_stall_o;
  logic [CmdW-1:0]     command_i       = '0;
  logic [DeltaW-1:0]   delta_us_i      = '0;
  logic                hold_i          = 1'b0;
  logic [CountW-1:0]   restore_value_i = '0;
  logic                out_valid_o;
  logic                out_stall_i     = 1'b0;
  logic                granted_o;
  logic [PendW-1:0]    ticks_due_o;
  logic [CountW-1:0]   dropped_taken_o;
  logic [CountW-1:0]   tick_total_o;

  fixed_step_tick_accumulator dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .command_i       (command_i),
    .delta_us_i      (delta_us_i),
    .hold_i          (hold_i),
    .restore_value_i (restore_value_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .granted_o       (granted_o),
    .ticks_due_o     (ticks_due_o),
    .dropped_taken_o (dropped_taken_o),
    .tick_total_o    (tick_total_o)
  );

  // predicted configuration and state
  logic [PeriodW-1:0] cfg_period = DefTickPeriod;
  logic [ScaleW-1:0]  cfg_scale  = DefTimeScale;
  logic [FrameW-1:0]  cfg_frame  = DefMaxFrame;
  logic [AccW-1:0]    exp_acc     = '0;
  logic [PendW-1:0]   exp_pending = '0;
  logic [CountW-1:0]  exp_ticks   = '0;
  logic [CountW-1:0]  exp_dropped = '0;

  tick_report_t reports_owed[$];
  int unsigned  error_count   = 0;
  int unsigned  requests_sent = 0;
  int unsigned  cycle_count   = 0;
  int unsigned  stall_left    = 0;
  logic         idle_on         = 1'b0;
  logic         hold_off_active = 1'b0;

  // fixed-step accumulation for one accepted request
  function automatic tick_report_t accumulate_step(logic [CmdW-1:0] cmd,
                                                   logic [DeltaW-1:0] delta,
                                                   logic hold,
                                                   logic [CountW-1:0] restore);
    tick_report_t rep;
    logic [63:0]  per, clamped, sum, whole, d64;
    rep.granted       = 1'b0;
    rep.dropped_taken = '0;
    d64 = 64'(delta);
    per = 64'((cfg_period == '0) ? DefTickPeriod : cfg_period) << FracW;
    case (cmd)
      CMD_ADVANCE: begin
        if (hold || delta == '0) begin
          exp_pending = '0;
        end else begin
          clamped = (d64 < 64'(cfg_frame)) ? d64 : 64'(cfg_frame);
          // time lost to clamping counts as dropped ticks
          if (d64 > clamped) exp_dropped += ((d64 - clamped) * 64'(cfg_scale)) / per;
          sum = 64'(exp_acc) + clamped * 64'(cfg_scale);
          whole = sum / per;
          exp_acc = 32'(sum - whole * per);
          exp_pending = (whole > 64'hFFFF_FFFF) ? '1 : whole[PendW-1:0];
        end
      end
      CMD_CONSUME: begin
        if (exp_pending != '0) begin
          exp_pending--;
          exp_ticks++;
          rep.granted = 1'b1;
        end
      end
      CMD_DROP: begin
        exp_dropped += 64'(exp_pending);
        exp_pending = '0;
      end
      CMD_TAKE: begin
        rep.dropped_taken = exp_dropped;
        exp_dropped = '0;
      end
      CMD_RESTORE: begin
        exp_ticks   = restore;
        exp_acc     = '0;
        exp_pending = '0;
      end
      default: ;
    endcase
    rep.ticks_due  = exp_pending;
    rep.tick_total = exp_ticks;
    return rep;
  endfunction

  function automatic logic [CountW-1:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic logic rand_bit();
    return 1'($urandom_range(0, 1));
  endfunction

  // elapsed times around the clamp and the tick period
  function automatic logic [DeltaW-1:0] pick_delta();
    logic [DeltaW-1:0] d;
    case ($urandom_range(0, 9))
      0: d = '0;
      1: d = $urandom;
      2: d = DeltaW'(cfg_frame) + DeltaW'($urandom_range(1, 5000));
      3: d = DeltaW'(cfg_frame);
      4, 5, 6: d = DeltaW'($urandom_range(1, 40000));
      default: d = DeltaW'($urandom_range(1, DeltaW'(cfg_frame) + 1));
    endcase
    return d;
  endfunction

  // one request, with an optional idle burst ahead of it
  task automatic send_request(logic [CmdW-1:0] cmd, logic [DeltaW-1:0] delta,
                              logic hold, logic [CountW-1:0] restore);
    if (idle_on && $urandom_range(0, 4) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
    end
    in_valid_i      <= 1'b1;
    command_i       <= cmd;
    delta_us_i      <= delta;
    hold_i          <= hold;
    restore_value_i <= restore;
    do @(posedge clk_i); while (in_stall_o);
    reports_owed.push_back(accumulate_step(cmd, delta, hold, restore));
    requests_sent++;
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (reports_owed.size() != 0);
  endtask

  // all three registers, one per cycle, block idle
  task automatic apply_settings(logic [PeriodW-1:0] period, logic [ScaleW-1:0] scale,
                                logic [FrameW-1:0] frame);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= CFG_TICK_PERIOD;
    cfg_data_i  <= CfgDataW'(period);
    @(posedge clk_i);
    cfg_period = period;
    cfg_index_i <= CFG_TIME_SCALE;
    cfg_data_i  <= {8'($urandom_range(0, 255)), scale};
    @(posedge clk_i);
    cfg_scale = scale;
    cfg_index_i <= CFG_MAX_FRAME;
    cfg_data_i  <= CfgDataW'(frame);
    @(posedge clk_i);
    cfg_frame = frame;
    cfg_we_i <= 1'b0;
  endtask

  // mostly game-loop frames: advance, then drain the ticks, plus noise
  task automatic run_random(int unsigned count);
    int unsigned target, n;
    target = requests_sent + count;
    while (requests_sent < target) begin
      if ($urandom_range(0, 9) < 6) begin
        send_request(CMD_ADVANCE, pick_delta(), $urandom_range(0, 9) == 0, rand64());
        n = ((exp_pending > 6) ? 6 : exp_pending) + $urandom_range(0, 1);
        repeat (n) send_request(CMD_CONSUME, $urandom, rand_bit(), rand64());
        if ($urandom_range(0, 7) == 0)
          send_request(CMD_TAKE, $urandom, rand_bit(), rand64());
      end else begin
        case ($urandom_range(0, 9))
          0: send_request(CMD_DROP, $urandom, rand_bit(), rand64());
          1: send_request(CMD_TAKE, $urandom, rand_bit(), rand64());
          2: send_request(CMD_RESTORE, $urandom, rand_bit(),
                          ($urandom_range(0, 1) != 0) ? ~64'($urandom_range(0, 3)) : rand64());
          3: send_request(CmdW'($urandom_range(CmdUnusedLo, CmdUnusedHi)), $urandom,
                          rand_bit(), rand64());
          4, 5: send_request(CMD_CONSUME, $urandom, rand_bit(), rand64());
          default: send_request(CMD_ADVANCE, $urandom, rand_bit(), rand64());
        endcase
      end
    end
  endtask

  task automatic run_phase(logic [PeriodW-1:0] period, logic [ScaleW-1:0] scale,
                           logic [FrameW-1:0] frame, int unsigned count, logic with_idle);
    wait_drained();
    apply_settings(period, scale, frame);
    idle_on <= with_idle;
    run_random(count);
  endtask

  // reset defaults, every command, clamping, wrap and the zero period
  task automatic test_directed();
    idle_on <= 1'b1;
    send_request(CMD_CONSUME, $urandom, 1'b0, rand64());
    send_request(CMD_ADVANCE, '0, 1'b0, rand64());
    send_request(CMD_ADVANCE, 32'd16667, 1'b0, rand64());
    send_request(CMD_ADVANCE, 32'd50000, 1'b1, rand64());
    send_request(CMD_ADVANCE, 32'd50001, 1'b0, rand64());
    send_request(CMD_CONSUME, $urandom, 1'b1, rand64());
    send_request(CMD_DROP, $urandom, 1'b0, rand64());
    send_request(CMD_ADVANCE, '1, 1'b0, rand64());
    send_request(CMD_TAKE, $urandom, 1'b1, rand64());
    send_request(CMD_TAKE, $urandom, 1'b0, rand64());
    send_request(CMD_RESTORE, '1, 1'b1, '1);
    send_request(CMD_ADVANCE, 32'd33334, 1'b0, '0);
    send_request(CMD_CONSUME, '0, 1'b0, '0);
    send_request(CMD_CONSUME, '1, 1'b1, '1);
    send_request(CMD_RESTORE, '0, 1'b0, 64'h8000_0000_0000_0001);
    send_request(CmdUnusedLo, '1, 1'b1, '1);
    send_request(CmdUnusedMid, '0, 1'b0, '0);
    send_request(CmdUnusedHi, $urandom, 1'b1, rand64());
    send_request(CMD_ADVANCE, 32'd250000, 1'b0, rand64());
    send_request(CMD_ADVANCE, 32'd250001, 1'b0, rand64());
    send_request(CMD_TAKE, '0, 1'b0, '0);
    // zero period falls back to the default period
    wait_drained();
    apply_settings('0, DefTimeScale, DefMaxFrame);
    send_request(CMD_ADVANCE, 32'd16667, 1'b0, rand64());
    send_request(CMD_ADVANCE, 32'd100000, 1'b0, rand64());
    send_request(CMD_CONSUME, $urandom, 1'b0, rand64());
  endtask

  // receiver holds off long enough for the block to stall its input
  task automatic test_long_stall();
    wait_drained();
    fork
      begin
        hold_off_active <= 1'b1;
        repeat (HoldOffCycles) @(posedge clk_i);
        hold_off_active <= 1'b0;
      end
    join_none
    repeat (16) begin
      case ($urandom_range(0, 2))
        0: send_request(CMD_CONSUME, $urandom, rand_bit(), rand64());
        1: send_request(CMD_TAKE, $urandom, rand_bit(), rand64());
        default: send_request(CMD_ADVANCE, pick_delta(), rand_bit(), rand64());
      endcase
    end
  endtask

  task automatic test_random_settings();
    run_phase(DefTickPeriod, DefTimeScale, DefMaxFrame, 200, 1'b1);
    run_phase(24'd1, 16'hFFFF, 24'hFF_FFFF, 200, 1'b1);
    run_phase(24'hFF_FFFF, 16'd1, 24'd1, 200, 1'b1);
    run_phase('0, '0, '0, 200, 1'b1);
    run_phase(24'd100, 16'd128, 24'd5000, 200, 1'b1);
    run_phase(PeriodW'($urandom_range(1, 20000)), ScaleW'($urandom), FrameW'($urandom),
              200, 1'b1);
    run_phase(PeriodW'($urandom), ScaleW'($urandom), FrameW'($urandom_range(1, 300000)),
              200, 1'b1);
  endtask

  task automatic test_random_no_idle();
    run_phase(DefTickPeriod, DefTimeScale, DefMaxFrame, 200, 1'b0);
  endtask

  // receiver stall bursts
  always @(posedge clk_i) begin
    if (hold_off_active) begin
      out_stall_i <= 1'b1;
    end else if (!idle_on) begin
      out_stall_i <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall_i <= 1'b1;
    end else if ($urandom_range(0, 9) == 0) begin
      stall_left = $urandom_range(0, 11);
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      error_count++;
    end
  endtask

  // compare each accepted result with the oldest prediction
  always @(posedge clk_i) begin : check_results
    tick_report_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (reports_owed.size() == 0) begin
        $display("%0t: result with no request outstanding, ticks_due %0h", $time,
                 ticks_due_o);
        error_count++;
      end else begin
        want = reports_owed.pop_front();
        check_field("granted", 64'(want.granted), 64'(granted_o));
        check_field("ticks_due", 64'(want.ticks_due), 64'(ticks_due_o));
        check_field("dropped_taken", want.dropped_taken, dropped_taken_o);
        check_field("tick_total", want.tick_total, tick_total_o);
      end
    end
  end

  // timeout
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= TimeoutCycles) begin
      $display("tb_top failed");
      $finish;
    end
  end

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_long_stall();
    test_random_settings();
    test_random_no_idle();
    wait_drained();
    repeat (DrainCycles) @(posedge clk_i);
    if (reports_owed.size() != 0) begin
      $display("%0t: %0d results never arrived", $time, reports_owed.size());
      error_count++;
    end
    if (error_count == 0) $display("tb_top passed");
    else $display("tb_top failed");
    $finish;
  end

endmodule
